>>> rtl/core/sprite_animation_sequencer_macros.svh
// ---------------------------------------------------------------------------
// Sprite animation sequencer assertion macros
// Shared property wrappers for same-cycle and next-cycle implications.
// ---------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SAS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sas_pkg.sv
// ---------------------------------------------------------------------------
// Sprite animation sequencer package
// Payload types, configuration type, action/style/register codes, helpers.
// ---------------------------------------------------------------------------
package sas_pkg;

  // Default table geometry
  localparam int MAX_FRAMES_DEF  = 16;
  localparam int MAX_COLUMNS_DEF = 4;
  localparam int MAX_ROWS_DEF    = 4;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // Input actions
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_HOLD   = 2'd1;
  localparam logic [1:0] ACT_TILE   = 2'd2;
  localparam logic [1:0] ACT_RENDER = 2'd3;

  // Animation styles
  localparam logic [1:0] STYLE_NONE = 2'd0;
  localparam logic [1:0] STYLE_ONCE = 2'd1;
  localparam logic [1:0] STYLE_LOOP = 2'd2;
  localparam logic [1:0] STYLE_PING = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ANIM_STYLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_COLS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_ROWS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SLOT  = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] frame_index;
    logic [1:0] tile_row;
    logic [1:0] tile_col;
    logic [7:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] sprite_slot;
    logic [7:0] tile_number;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] anim_style;
    logic [4:0] frame_count;
    logic [2:0] tile_columns;
    logic [2:0] tile_rows;
    logic [5:0] first_sprite_slot;
  } cfg_t;

  // Index width for a store of the given depth, at least one bit
  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> rtl/core/sas_ram.sv
// ---------------------------------------------------------------------------
// Sprite animation sequencer RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module sas_ram
  import sas_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [addr_w(DEPTH)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]          wr_data,
  input  logic [addr_w(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/sas_ctrl.sv
// ---------------------------------------------------------------------------
// Sprite animation sequencer control
// Frame stepping, hold countdown and the tile-by-tile render sequencer.
// ---------------------------------------------------------------------------
`include "sprite_animation_sequencer_macros.svh"

module sas_ctrl
  import sas_pkg::*;
#(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 start,
  output logic                                                 busy,
  input  in_item_t                                             in_data,
  input  cfg_t                                                 cfg,
  output logic                                                 hold_we,
  output logic [addr_w(MAX_FRAMES)-1:0]                        hold_waddr,
  output logic [addr_w(MAX_FRAMES)-1:0]                        hold_raddr,
  input  logic [7:0]                                           hold_rdata,
  output logic                                                 tile_we,
  output logic [addr_w(MAX_FRAMES*MAX_ROWS*MAX_COLUMNS)-1:0]   tile_waddr,
  output logic [addr_w(MAX_FRAMES*MAX_ROWS*MAX_COLUMNS)-1:0]   tile_raddr,
  input  logic [7:0]                                           tile_rdata,
  output logic                                                 out_valid,
  output out_item_t                                            out_data
);

  localparam int FW  = addr_w(MAX_FRAMES);
  localparam int CW  = addr_w(MAX_COLUMNS);
  localparam int RW  = addr_w(MAX_ROWS);
  localparam int TAW = addr_w(MAX_FRAMES * MAX_ROWS * MAX_COLUMNS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [FW-1:0] frame_r, frame_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic          back_r, back_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [5:0]    slot_r, slot_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_slot_r, out_slot_nxt;
  logic          out_last_r, out_last_nxt;

  logic          acc;
  logic [6:0]    fc_ext, fc_cl;
  logic [FW-1:0] last_frame;
  logic [3:0]    cols_ext, cols_cl, rows_ext, rows_cl;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;
  logic          is_last;
  logic          at_last;
  logic          adv_render;
  logic [FW-1:0] frame_adv;
  logic          back_adv;
  logic          dir;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  // Clamp frame count and tile geometry into range
  always_comb begin
    fc_ext   = {2'b00, cfg.frame_count};
    cols_ext = {1'b0, cfg.tile_columns};
    rows_ext = {1'b0, cfg.tile_rows};
    if (fc_ext == 7'd0) begin
      fc_cl = 7'd1;
    end else if (32'(fc_ext) > MAX_FRAMES) begin
      fc_cl = 7'(MAX_FRAMES);
    end else begin
      fc_cl = fc_ext;
    end
    if (cols_ext == 4'd0) begin
      cols_cl = 4'd1;
    end else if (32'(cols_ext) > MAX_COLUMNS) begin
      cols_cl = 4'(MAX_COLUMNS);
    end else begin
      cols_cl = cols_ext;
    end
    if (rows_ext == 4'd0) begin
      rows_cl = 4'd1;
    end else if (32'(rows_ext) > MAX_ROWS) begin
      rows_cl = 4'(MAX_ROWS);
    end else begin
      rows_cl = rows_ext;
    end
  end

  assign last_frame = FW'(fc_cl - 7'd1);
  assign col_last   = CW'(cols_cl - 4'd1);
  assign row_last   = RW'(rows_cl - 4'd1);
  assign is_last    = (col_r == col_last) && (row_r == row_last);
  assign at_last    = (frame_r >= last_frame);

  // Step the frame by style on an expired tick
  always_comb begin
    frame_adv  = frame_r;
    back_adv   = back_r;
    adv_render = 1'b0;
    dir        = back_r;
    case (cfg.anim_style)
      STYLE_ONCE: begin
        if (!at_last) begin
          frame_adv  = frame_r + FW'(1);
          adv_render = 1'b1;
        end
      end
      STYLE_LOOP: begin
        frame_adv  = at_last ? '0 : frame_r + FW'(1);
        adv_render = 1'b1;
      end
      STYLE_PING: begin
        adv_render = 1'b1;
        if (last_frame == '0) begin
          frame_adv = '0;
          back_adv  = 1'b0;
        end else begin
          if (frame_r == '0) begin
            dir = 1'b0;
          end else if (at_last) begin
            dir = 1'b1;
          end
          back_adv  = dir;
          frame_adv = dir ? frame_r - FW'(1) : frame_r + FW'(1);
        end
      end
      default: begin
        adv_render = 1'b0;
      end
    endcase
  end

  // Table writes go straight to the memories
  assign hold_we    = acc && (in_data.action == ACT_HOLD)
                      && (32'(in_data.frame_index) < MAX_FRAMES);
  assign hold_waddr = FW'(in_data.frame_index);
  assign tile_we    = acc && (in_data.action == ACT_TILE)
                      && (32'(in_data.frame_index) < MAX_FRAMES)
                      && (32'(in_data.tile_row) < MAX_ROWS)
                      && (32'(in_data.tile_col) < MAX_COLUMNS);
  assign tile_waddr = TAW'((32'(in_data.frame_index) * MAX_ROWS + 32'(in_data.tile_row))
                           * MAX_COLUMNS + 32'(in_data.tile_col));
  assign tile_raddr = TAW'((32'(frame_r) * MAX_ROWS + 32'(row_r)) * MAX_COLUMNS
                           + 32'(col_r));
  assign hold_raddr = frame_r;

  // Sequencer: accept, walk the tiles, then reload the hold count
  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    hold_nxt      = hold_r;
    back_nxt      = back_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.action == ACT_TICK) begin
            if (hold_r != 8'd0) begin
              hold_nxt = hold_r - 8'd1;
            end else if (adv_render) begin
              frame_nxt = frame_adv;
              back_nxt  = back_adv;
              state_nxt = S_RUN;
              col_nxt   = '0;
              row_nxt   = '0;
              slot_nxt  = cfg.first_sprite_slot;
            end
          end else if (in_data.action == ACT_RENDER) begin
            state_nxt = S_RUN;
            col_nxt   = '0;
            row_nxt   = '0;
            slot_nxt  = cfg.first_sprite_slot;
          end
        end
      end
      S_RUN: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = slot_r;
        out_last_nxt  = is_last;
        slot_nxt      = slot_r + 6'd1;
        if (col_r == col_last) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
        if (is_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        hold_nxt  = hold_rdata;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_r     <= '0;
      hold_r      <= 8'd0;
      back_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      hold_r      <= hold_nxt;
      back_r      <= back_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_data.sprite_slot = out_slot_r;
  assign out_data.tile_number = tile_rdata;
  assign out_data.last_of_run = out_last_r;

  `SAS_ASSERT_SAME(a_out_while_busy, clk, rst_n, out_valid_r, busy, "result outside a render")
  `SAS_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_valid_r && out_last_r,
    !out_valid_r && (state_r == S_IDLE), "render did not end after last tile")
  `SAS_ASSERT_SAME(a_drain_shows_last, clk, rst_n, state_r == S_DRAIN,
    out_valid_r && out_last_r, "drain without final tile")
  `SAS_ASSERT_NEXT(a_hold_counts_down, clk, rst_n,
    acc && (in_data.action == ACT_TICK) && (hold_r != 8'd0),
    (hold_r == $past(hold_r) - 8'd1) && (state_r == S_IDLE), "hold countdown slipped")

endmodule

>>> rtl/core/sprite_animation_sequencer.sv
// ---------------------------------------------------------------------------
// Sprite animation sequencer
// Steps multi-tile sprite frames and emits per-tile slot updates.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: present in_data with start high; the transaction is taken
//   at a rising edge where start is high and busy is low.
//   Hold-time writes, tile writes, and ticks that only count down or do not
//   advance leave busy low.
//   A render (forced, or a tick that advances the frame) of N = rows * cols
//   tiles keeps busy high while S_RUN walks the tiles and through S_DRAIN;
//   the next transaction is taken once busy is low. Results appear on out_data
//   with out_valid high for one cycle each, N results in a row, out_valid being
//   registered from S_RUN; last_of_run marks the final one. One tile
//   per cycle is set by the single tile-memory read port.
//   The receiver cannot stall: every strobed result is taken as it appears.
//   Configuration: write cfg_data to register cfg_index when cfg_valid is
//   high; cfg_ready is always high. Write only while busy is low.
//   Reset (rst_n low, synchronous) returns to frame 0, hold count 0, forward
//   direction, and default configuration. Hold and tile tables are not
//   cleared and must be written before they are read.
// ---------------------------------------------------------------------------
module sprite_animation_sequencer
  import sas_pkg::*;
#(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_data,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int FW  = addr_w(MAX_FRAMES);
  localparam int TD  = MAX_FRAMES * MAX_ROWS * MAX_COLUMNS;
  localparam int TAW = addr_w(TD);

  cfg_t          cfg_r, cfg_nxt;
  logic          hold_we;
  logic [FW-1:0] hold_waddr, hold_raddr;
  logic [7:0]    hold_rdata;
  logic          tile_we;
  logic [TAW-1:0] tile_waddr, tile_raddr;
  logic [7:0]    tile_rdata;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANIM_STYLE:  cfg_nxt.anim_style        = cfg_data[1:0];
        REG_FRAME_COUNT: cfg_nxt.frame_count       = cfg_data[4:0];
        REG_TILE_COLS:   cfg_nxt.tile_columns      = cfg_data[2:0];
        REG_TILE_ROWS:   cfg_nxt.tile_rows         = cfg_data[2:0];
        REG_FIRST_SLOT:  cfg_nxt.first_sprite_slot = cfg_data[5:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.anim_style        <= STYLE_NONE;
      cfg_r.frame_count       <= 5'd1;
      cfg_r.tile_columns      <= 3'd1;
      cfg_r.tile_rows         <= 3'd1;
      cfg_r.first_sprite_slot <= 6'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sas_ctrl #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .hold_we    (hold_we),
    .hold_waddr (hold_waddr),
    .hold_raddr (hold_raddr),
    .hold_rdata (hold_rdata),
    .tile_we    (tile_we),
    .tile_waddr (tile_waddr),
    .tile_raddr (tile_raddr),
    .tile_rdata (tile_rdata),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  sas_ram #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (8)
  ) u_hold_ram (
    .clk     (clk),
    .wr_en   (hold_we),
    .wr_addr (hold_waddr),
    .wr_data (in_data.write_value),
    .rd_addr (hold_raddr),
    .rd_data (hold_rdata)
  );

  sas_ram #(
    .DEPTH (TD),
    .WIDTH (8)
  ) u_tile_ram (
    .clk     (clk),
    .wr_en   (tile_we),
    .wr_addr (tile_waddr),
    .wr_data (in_data.write_value),
    .rd_addr (tile_raddr),
    .rd_data (tile_rdata)
  );

endmodule
